FILE: hdl/ptc_pkg.sv
// Shared widths, constants and types of the pressure/temperature compensation block.
package ptc_pkg;

  localparam int COEFF_W = 16;
  localparam int RAW_W   = 24;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // Datapath widths, sized to the worst case of each intermediate value.
  localparam int DT_W    = RAW_W + 1;
  localparam int PROD1_W = DT_W + COEFF_W + 1;
  localparam int DT2_W   = 2 * DT_W;
  localparam int DTEMP_W = 18;
  localparam int TEMP_W  = 20;
  localparam int T2_W    = 18;
  localparam int SQ_W    = 35;
  localparam int OFF_W   = 38;
  localparam int SENS_W  = 37;
  localparam int SPLIT_W = 18;
  localparam int HI_W    = SENS_W - SPLIT_W;
  localparam int PLO_W   = RAW_W + SPLIT_W;
  localparam int PHI_W   = RAW_W + 1 + HI_W;
  localparam int PROD_W  = 62;
  localparam int DIFF_W  = PROD_W - 20;
  localparam int TOUT_W  = 15;
  localparam int POUT_W  = 18;

  localparam int TEMP_MIN = -4000;
  localparam int TEMP_MAX = 8500;
  localparam int PRES_MAX = 160000;
  localparam logic signed [TEMP_W-1:0] TEMP_REF = TEMP_W'(2000);

  typedef struct packed {
    logic [COEFF_W-1:0] sens_coeff;
    logic [COEFF_W-1:0] offset_coeff;
    logic [COEFF_W-1:0] sens_temp_coeff;
    logic [COEFF_W-1:0] offset_temp_coeff;
    logic [COEFF_W-1:0] ref_temperature;
    logic [COEFF_W-1:0] temp_coeff;
  } coeff_t;

  // First-order results handed from the front half to the back half.
  typedef struct packed {
    logic [RAW_W-1:0]          d1;
    logic signed [DTEMP_W-1:0] dtemp;
    logic signed [TEMP_W-1:0]  temp;
    logic signed [OFF_W-1:0]   off;
    logic signed [SENS_W-1:0]  sens;
    logic [T2_W-1:0]           t2;
    logic                      cold;
  } first_t;

endpackage

FILE: hdl/ptc_cfg_regs.sv
// Calibration register file behind the APB-style configuration port.
module ptc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ptc_pkg::ADDR_W-1:0]  paddr,
  input  logic [ptc_pkg::DATA_W-1:0]  pwdata,
  output logic [ptc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output ptc_pkg::coeff_t             coeff
);
  import ptc_pkg::*;

  localparam logic [2:0] IDX_SENS        = 3'd0;
  localparam logic [2:0] IDX_OFFSET      = 3'd1;
  localparam logic [2:0] IDX_SENS_TEMP   = 3'd2;
  localparam logic [2:0] IDX_OFFSET_TEMP = 3'd3;
  localparam logic [2:0] IDX_REF_TEMP    = 3'd4;
  localparam logic [2:0] IDX_TEMP        = 3'd5;

  logic [2:0]         idx;
  logic               wr;
  logic [COEFF_W-1:0] wval;
  logic [COEFF_W-1:0] rval;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign wval   = pwdata[COEFF_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff <= '0;
    end else if (wr) begin
      case (idx)
        IDX_SENS:        coeff.sens_coeff        <= wval;
        IDX_OFFSET:      coeff.offset_coeff      <= wval;
        IDX_SENS_TEMP:   coeff.sens_temp_coeff   <= wval;
        IDX_OFFSET_TEMP: coeff.offset_temp_coeff <= wval;
        IDX_REF_TEMP:    coeff.ref_temperature   <= wval;
        IDX_TEMP:        coeff.temp_coeff        <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      IDX_SENS:        rval = coeff.sens_coeff;
      IDX_OFFSET:      rval = coeff.offset_coeff;
      IDX_SENS_TEMP:   rval = coeff.sens_temp_coeff;
      IDX_OFFSET_TEMP: rval = coeff.offset_temp_coeff;
      IDX_REF_TEMP:    rval = coeff.ref_temperature;
      IDX_TEMP:        rval = coeff.temp_coeff;
      default:         rval = '0;
    endcase
  end

  assign prdata = {{(DATA_W-COEFF_W){1'b0}}, rval};

endmodule

FILE: hdl/ptc_first_order.sv
// Front pipeline stages: temperature difference, coefficient products, first-order terms.
module ptc_first_order (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [ptc_pkg::RAW_W-1:0]  raw_pressure,
  input  logic [ptc_pkg::RAW_W-1:0]  raw_temperature,
  input  ptc_pkg::coeff_t            coeff,
  output logic                       first_valid,
  output ptc_pkg::first_t            first
);
  import ptc_pkg::*;

  localparam int SUM_W = T2_W + 37;

  // Stage A: temperature difference.
  logic                     a_valid;
  logic [RAW_W-1:0]         a_d1;
  logic signed [DT_W-1:0]   a_dt;
  logic signed [DT_W-1:0]   dt_next;

  // Stage B: products of dT.
  logic                      b_valid;
  logic [RAW_W-1:0]          b_d1;
  logic signed [PROD1_W-1:0] b_p_temp;
  logic signed [PROD1_W-1:0] b_p_off;
  logic signed [PROD1_W-1:0] b_p_sens;
  logic signed [DT2_W-1:0]   b_dt2;

  // Stage C: first-order values.
  logic signed [DTEMP_W-1:0] dtemp_next;
  logic [SUM_W-1:0]          dt2_ext;
  logic [SUM_W-1:0]          dt2_x3;
  logic [SUM_W-1:0]          dt2_x7;
  first_t                    c_next;

  assign dt_next = $signed({1'b0, raw_temperature})
                 - $signed({1'b0, coeff.ref_temperature, 8'd0});

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid     <= 1'b0;
      b_valid     <= 1'b0;
      first_valid <= 1'b0;
    end else if (en) begin
      a_valid     <= in_valid;
      b_valid     <= a_valid;
      first_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_d1     <= raw_pressure;
      a_dt     <= dt_next;
      b_d1     <= a_d1;
      b_p_temp <= a_dt * $signed({1'b0, coeff.temp_coeff});
      b_p_off  <= a_dt * $signed({1'b0, coeff.offset_temp_coeff});
      b_p_sens <= a_dt * $signed({1'b0, coeff.sens_temp_coeff});
      b_dt2    <= a_dt * a_dt;
      first    <= c_next;
    end
  end

  // dT squared is never negative, so the second-order shifts are plain shifts.
  assign dt2_ext    = SUM_W'($unsigned(b_dt2));
  assign dt2_x3     = dt2_ext + (dt2_ext << 1);
  assign dt2_x7     = (dt2_ext << 3) - dt2_ext;
  assign dtemp_next = b_p_temp[23 +: DTEMP_W];

  always_comb begin
    c_next.d1    = b_d1;
    c_next.dtemp = dtemp_next;
    c_next.temp  = TEMP_REF + TEMP_W'(dtemp_next);
    c_next.off   = $signed({{(OFF_W-COEFF_W-16){1'b0}}, coeff.offset_coeff, 16'd0})
                 + OFF_W'(b_p_off >>> 7);
    c_next.sens  = $signed({{(SENS_W-COEFF_W-15){1'b0}}, coeff.sens_coeff, 15'd0})
                 + SENS_W'(b_p_sens >>> 8);
    c_next.cold  = dtemp_next[DTEMP_W-1];
    c_next.t2    = dtemp_next[DTEMP_W-1] ? dt2_x3[33 +: T2_W] : dt2_x7[37 +: T2_W];
  end

endmodule

FILE: hdl/ptc_second_order.sv
// Back pipeline stages: second-order corrections, pressure product, saturation.
module ptc_second_order (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              first_valid,
  input  ptc_pkg::first_t                   first,
  output logic                              out_valid,
  output logic signed [ptc_pkg::TOUT_W-1:0] temperature_centi,
  output logic [ptc_pkg::POUT_W-1:0]        pressure_decimbar,
  output logic                              clamped
);
  import ptc_pkg::*;

  // Stage D: square of the temperature deviation, corrected temperature.
  logic                        d_valid;
  logic [RAW_W-1:0]            d_d1;
  logic [SQ_W-1:0]             d_sq;
  logic signed [TEMP_W-1:0]    d_temp;
  logic signed [OFF_W-1:0]     d_off;
  logic signed [SENS_W-1:0]    d_sens;
  logic                        d_cold;
  logic signed [2*DTEMP_W-1:0] sq_full;

  // Stage E: corrected offset and sensitivity.
  logic                     e_valid;
  logic [RAW_W-1:0]         e_d1;
  logic signed [TEMP_W-1:0] e_temp;
  logic signed [OFF_W-1:0]  e_off;
  logic signed [SENS_W-1:0] e_sens;
  logic [SQ_W+1:0]          sq_x3;
  logic [SQ_W+1:0]          sq_x5;
  logic [OFF_W-1:0]         off2;
  logic [SENS_W-1:0]        sens2;

  // Stage F: partial products of D1 times the sensitivity.
  logic                     f_valid;
  logic signed [TEMP_W-1:0] f_temp;
  logic signed [OFF_W-1:0]  f_off;
  logic [PLO_W-1:0]         f_plo;
  logic signed [PHI_W-1:0]  f_phi;
  logic signed [PHI_W-1:0]  phi_next;

  // Stage G: full product.
  logic                     g_valid;
  logic signed [TEMP_W-1:0] g_temp;
  logic signed [OFF_W-1:0]  g_off;
  logic signed [PROD_W-1:0] g_prod;

  // Output stage: pressure and saturation.
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] pres_raw;
  logic                     t_lo;
  logic                     t_hi;
  logic                     p_lo;
  logic                     p_hi;

  assign sq_full  = first.dtemp * first.dtemp;
  assign sq_x3    = {2'b0, d_sq} + {1'b0, d_sq, 1'b0};
  assign sq_x5    = {2'b0, d_sq} + {d_sq, 2'b0};
  assign off2     = d_cold ? OFF_W'(sq_x3 >> 1) : OFF_W'(d_sq >> 4);
  assign sens2    = d_cold ? SENS_W'(sq_x5 >> 3) : '0;
  assign phi_next = $signed({1'b0, e_d1}) * $signed(e_sens[SENS_W-1:SPLIT_W]);

  assign diff     = DIFF_W'(g_prod >>> 21) - DIFF_W'(g_off);
  assign pres_raw = diff >>> 15;
  assign t_lo     = g_temp < TEMP_MIN;
  assign t_hi     = g_temp > TEMP_MAX;
  assign p_lo     = pres_raw < 0;
  assign p_hi     = pres_raw > PRES_MAX;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid   <= 1'b0;
      e_valid   <= 1'b0;
      f_valid   <= 1'b0;
      g_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      d_valid   <= first_valid;
      e_valid   <= d_valid;
      f_valid   <= e_valid;
      g_valid   <= f_valid;
      out_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_d1   <= first.d1;
      d_sq   <= sq_full[SQ_W-1:0];
      d_temp <= first.temp - $signed({{(TEMP_W-T2_W){1'b0}}, first.t2});
      d_off  <= first.off;
      d_sens <= first.sens;
      d_cold <= first.cold;

      e_d1   <= d_d1;
      e_temp <= d_temp;
      e_off  <= d_off - $signed(off2);
      e_sens <= d_sens - $signed(sens2);

      f_temp <= e_temp;
      f_off  <= e_off;
      f_plo  <= e_d1 * e_sens[SPLIT_W-1:0];
      f_phi  <= phi_next;

      g_temp <= f_temp;
      g_off  <= f_off;
      g_prod <= (PROD_W'(f_phi) <<< SPLIT_W) + $signed({{(PROD_W-PLO_W){1'b0}}, f_plo});

      if (t_lo) begin
        temperature_centi <= TOUT_W'(TEMP_MIN);
      end else if (t_hi) begin
        temperature_centi <= TOUT_W'(TEMP_MAX);
      end else begin
        temperature_centi <= g_temp[TOUT_W-1:0];
      end
      if (p_lo) begin
        pressure_decimbar <= '0;
      end else if (p_hi) begin
        pressure_decimbar <= POUT_W'(PRES_MAX);
      end else begin
        pressure_decimbar <= pres_raw[POUT_W-1:0];
      end
      clamped <= t_lo || t_hi || p_lo || p_hi;
    end
  end

endmodule

FILE: hdl/pressure_temp_compensation_top.sv
// Top level of the second-order pressure/temperature compensation pipeline.
// A word accepted into stage A passes in order through stages B to G into the output register.
// Throughput: one word per cycle; a stalled output word freezes all eight stages.
// The output register holds the stalled word while the input is stalled in step.
// Reset clears every stage valid bit and sets all six calibration registers to zero.
module pressure_temp_compensation_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ptc_pkg::RAW_W-1:0]         raw_pressure,
  input  logic [ptc_pkg::RAW_W-1:0]         raw_temperature,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ptc_pkg::TOUT_W-1:0] temperature_centi,
  output logic [ptc_pkg::POUT_W-1:0]        pressure_decimbar,
  output logic                              clamped,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ptc_pkg::ADDR_W-1:0]        paddr,
  input  logic [ptc_pkg::DATA_W-1:0]        pwdata,
  output logic [ptc_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);
  import ptc_pkg::*;

  coeff_t coeff;
  first_t first;
  logic   first_valid;
  logic   en;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  ptc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coeff   (coeff)
  );

  ptc_first_order u_first (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .in_valid        (in_valid),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .coeff           (coeff),
    .first_valid     (first_valid),
    .first           (first)
  );

  ptc_second_order u_second (
    .clk               (clk),
    .rst               (rst),
    .en                (en),
    .first_valid       (first_valid),
    .first             (first),
    .out_valid         (out_valid),
    .temperature_centi (temperature_centi),
    .pressure_decimbar (pressure_decimbar),
    .clamped           (clamped)
  );

endmodule

FILE: hdl/ptc_checker.sv
// Port-level checks of the compensation block, bound to its top level.
module ptc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [ptc_pkg::TOUT_W-1:0] temperature_centi,
  input logic [ptc_pkg::POUT_W-1:0]        pressure_decimbar
);
  import ptc_pkg::*;

  // The pipeline comes out of reset empty.
  a_empty_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word present right after reset");

  // A stalled output word stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled output word dropped");

  // The input is only held off when the output word is blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output is free");

  // Delivered values always lie inside their saturation ranges.
  a_ranges: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pressure_decimbar <= POUT_W'(PRES_MAX)
               && temperature_centi >= TOUT_W'(TEMP_MIN)
               && temperature_centi <= TOUT_W'(TEMP_MAX))
    else $error("output word outside its range");

endmodule

bind pressure_temp_compensation_top ptc_checker u_checker (.*);
